FILE: rtl/core/tld_pkg.sv
// shared constants, codes and controller/datapath link types for the task location directory
`default_nettype none

package tld_pkg;

   localparam int LOCAL_SLOTS_DEF   = 4;
   localparam int TASKS_PER_APP_DEF = 16;

   localparam logic [2:0] OP_INIT   = 3'd0;
   localparam logic [2:0] OP_INSERT = 3'd1;
   localparam logic [2:0] OP_SEARCH = 3'd2;
   localparam logic [2:0] OP_LENGTH = 3'd3;
   localparam logic [2:0] OP_BCAST  = 3'd4;

   localparam logic [16:0] LOC_UNKNOWN = 17'h1FFFF;
   localparam logic [15:0] INDEX_MASK  = 16'h00FF;
   localparam logic [15:0] APP_MASK    = 16'hFF00;

   typedef struct packed {
      logic capture;
      logic cnt_clr;
      logic clr_wr;
      logic bind_wr;
      logic fill_wr;
      logic ins_wr;
      logic srch_rd;
      logic scan_step;
      logic bcast_step;
      logic load_rsp;
   } tld_cmd_type;

   typedef struct packed {
      logic [2:0] op;
      logic       slot_ok;
      logic       idx_ok;
      logic       clr_last;
      logic       fill_last;
      logic       scan_hit;
      logic       scan_last;
      logic       bcast_last;
   } tld_status_type;

endpackage

`default_nettype wire

FILE: rtl/core/tld_if.sv
// request and response channel interfaces of the task location directory
`default_nettype none

interface tld_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         req_type;
   logic [1:0]         slot;
   logic [15:0]        task_id;
   logic signed [16:0] location;

   modport source (output valid, req_type, slot, task_id, location, input ready);
   modport sink (input valid, req_type, slot, task_id, location, output ready);
endinterface

interface tld_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [16:0] found_location;
   logic [4:0]         known_length;
   logic               index_error;

   modport source (output valid, found_location, known_length, index_error, input ready);
   modport sink (input valid, found_location, known_length, index_error, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/task_location_directory.sv
// top level of the task location directory
//
//   channel   dir   handshake      payload
//   req_bus   in    valid/ready    req_type, slot, task_id, location
//   rsp_bus   out   valid/ready    found_location, known_length, index_error
//
// one request at a time; insert, search and rejected requests go from the exec state straight to done
// init binds the slot, then writes one table entry per cycle in the fill state
// length reads one entry per cycle until the first unknown entry or the end of the slot's row
// broadcast update visits one slot per cycle
// after reset a clearing pass over all LOCAL_SLOTS * TASKS_PER_APP entries holds req_bus.ready low
// a response waiting in the output register does not block the next request from being taken
`default_nettype none

module task_location_directory #(
   parameter int LOCAL_SLOTS   = tld_pkg::LOCAL_SLOTS_DEF,
   parameter int TASKS_PER_APP = tld_pkg::TASKS_PER_APP_DEF
) (
   input  logic       clock,
   input  logic       reset,
   tld_req_if.sink    req_bus,
   tld_rsp_if.source  rsp_bus
);

   tld_pkg::tld_cmd_type    cmd;
   tld_pkg::tld_status_type status;

   tld_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   tld_datapath #(
      .LOCAL_SLOTS   (LOCAL_SLOTS),
      .TASKS_PER_APP (TASKS_PER_APP)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_type       (req_bus.req_type),
      .slot           (req_bus.slot),
      .task_id        (req_bus.task_id),
      .location       (req_bus.location),
      .found_location (rsp_bus.found_location),
      .known_length   (rsp_bus.known_length),
      .index_error    (rsp_bus.index_error)
   );

endmodule

`default_nettype wire

FILE: rtl/core/tld_datapath.sv
// datapath of the task location directory: request registers, location memory, slot ids, results
`default_nettype none

module tld_datapath #(
   parameter int LOCAL_SLOTS   = tld_pkg::LOCAL_SLOTS_DEF,
   parameter int TASKS_PER_APP = tld_pkg::TASKS_PER_APP_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  tld_pkg::tld_cmd_type   cmd,
   output tld_pkg::tld_status_type status,
   input  logic [2:0]             req_type,
   input  logic [1:0]             slot,
   input  logic [15:0]            task_id,
   input  logic signed [16:0]     location,
   output logic signed [16:0]     found_location,
   output logic [4:0]             known_length,
   output logic                   index_error
);

   localparam int DEPTH = LOCAL_SLOTS * TASKS_PER_APP;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = AW + 1;
   localparam int IW    = (TASKS_PER_APP > 1) ? $clog2(TASKS_PER_APP) : 1;
   localparam int SW    = (LOCAL_SLOTS > 1) ? $clog2(LOCAL_SLOTS) : 1;

   logic [16:0]        mem [DEPTH];

   logic [2:0]         type_ff;
   logic [1:0]         slot_ff;
   logic [15:0]        tid_ff;
   logic [16:0]        loc_ff;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic               rd_vld_ff;
   logic [CW-1:0]      chk_ff;
   logic [CW-1:0]      len_ff;
   logic [16:0]        rd_data_ff;
   logic [15:0]        sid_ff [LOCAL_SLOTS];
   logic signed [16:0] found_ff, found_in;
   logic [4:0]         len_out_ff, len_out_in;
   logic               err_ff, err_in;

   logic               slot_ok, idx_ok;
   logic [15:0]        idx_full;
   logic [IW-1:0]      idx, cnt_idx;
   logic [SW-1:0]      slot_sel, cnt_slot;
   logic [AW-1:0]      row_slot, row_cnt;
   logic               scan_issue, bcast_match;
   logic               we, re;
   logic [AW-1:0]      waddr, raddr;
   logic [16:0]        wdata;

   assign slot_ok     = 32'(slot_ff) < LOCAL_SLOTS;
   assign idx_full    = tid_ff & tld_pkg::INDEX_MASK;
   assign idx_ok      = 32'(idx_full) < TASKS_PER_APP;
   assign idx         = idx_full[IW-1:0];
   assign cnt_idx     = cnt_ff[IW-1:0];
   assign slot_sel    = SW'(slot_ff);
   assign cnt_slot    = cnt_ff[SW-1:0];
   assign row_slot    = AW'(32'(slot_ff) * TASKS_PER_APP);
   assign row_cnt     = AW'(32'(cnt_ff) * TASKS_PER_APP);
   assign scan_issue  = cmd.scan_step && (32'(cnt_ff) < TASKS_PER_APP);
   assign bcast_match = (sid_ff[cnt_slot] & tld_pkg::APP_MASK) == (tid_ff & tld_pkg::APP_MASK);

   always_comb begin
      we    = 1'b0;
      waddr = row_slot + AW'(idx);
      wdata = loc_ff;
      if (cmd.clr_wr) begin
         we    = 1'b1;
         waddr = cnt_ff[AW-1:0];
         wdata = tld_pkg::LOC_UNKNOWN;
      end else if (cmd.fill_wr) begin
         we    = 1'b1;
         waddr = row_slot + AW'(cnt_idx);
         wdata = tld_pkg::LOC_UNKNOWN;
      end else if (cmd.ins_wr) begin
         we    = 1'b1;
      end else if (cmd.bcast_step) begin
         we    = bcast_match;
         waddr = row_cnt + AW'(idx);
      end
   end

   assign re    = cmd.srch_rd || scan_issue;
   assign raddr = cmd.scan_step ? (row_slot + AW'(cnt_idx)) : (row_slot + AW'(idx));

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rd_data_ff <= mem[raddr];
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.cnt_clr) begin
         cnt_in = '0;
      end else if (cmd.clr_wr || cmd.fill_wr || cmd.bcast_step || scan_issue) begin
         cnt_in = cnt_ff + CW'(1);
      end
   end

   always_comb begin
      status.op         = type_ff;
      status.slot_ok    = slot_ok;
      status.idx_ok     = idx_ok;
      status.clr_last   = 32'(cnt_ff) == DEPTH - 1;
      status.fill_last  = 32'(cnt_ff) == TASKS_PER_APP - 1;
      status.bcast_last = 32'(cnt_ff) == LOCAL_SLOTS - 1;
      status.scan_hit   = rd_vld_ff && (rd_data_ff == tld_pkg::LOC_UNKNOWN);
      status.scan_last  = rd_vld_ff && (32'(chk_ff) == TASKS_PER_APP - 1);
   end

   always_comb begin
      found_in   = '0;
      len_out_in = '0;
      err_in     = 1'b0;
      case (type_ff)
         tld_pkg::OP_INSERT: begin
            err_in = slot_ok && !idx_ok;
         end
         tld_pkg::OP_SEARCH: begin
            if (slot_ok) begin
               found_in = idx_ok ? rd_data_ff : tld_pkg::LOC_UNKNOWN;
               err_in   = !idx_ok;
            end
         end
         tld_pkg::OP_LENGTH: begin
            if (slot_ok) begin
               len_out_in = 5'(len_ff);
            end
         end
         tld_pkg::OP_BCAST: begin
            err_in = !idx_ok;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         rd_vld_ff <= 1'b0;
         for (int i = 0; i < LOCAL_SLOTS; i++) begin
            sid_ff[i] <= '0;
         end
      end else begin
         cnt_ff    <= cnt_in;
         rd_vld_ff <= scan_issue;
         if (cmd.bind_wr) begin
            sid_ff[slot_sel] <= tid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         type_ff <= req_type;
         slot_ff <= slot;
         tid_ff  <= task_id;
         loc_ff  <= location;
      end
      if (scan_issue) begin
         chk_ff <= cnt_ff;
      end
      if (cmd.scan_step) begin
         if (status.scan_hit) begin
            len_ff <= chk_ff;
         end else if (status.scan_last) begin
            len_ff <= CW'(TASKS_PER_APP);
         end
      end
      if (cmd.load_rsp) begin
         found_ff   <= found_in;
         len_out_ff <= len_out_in;
         err_ff     <= err_in;
      end
   end

   assign found_location = found_ff;
   assign known_length   = len_out_ff;
   assign index_error    = err_ff;

endmodule

`default_nettype wire

FILE: rtl/core/tld_controller.sv
// control state machine of the task location directory
`default_nettype none

module tld_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  tld_pkg::tld_status_type status,
   output tld_pkg::tld_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_FILL,
      ST_SCAN,
      ST_BCAST,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (status.clr_last) begin
               cmd.cnt_clr = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.cnt_clr = 1'b1;
            state_in    = ST_DONE;
            case (status.op)
               tld_pkg::OP_INIT: begin
                  if (status.slot_ok) begin
                     cmd.bind_wr = 1'b1;
                     state_in    = ST_FILL;
                  end
               end
               tld_pkg::OP_INSERT: begin
                  cmd.ins_wr = status.slot_ok && status.idx_ok;
               end
               tld_pkg::OP_SEARCH: begin
                  cmd.srch_rd = status.slot_ok && status.idx_ok;
               end
               tld_pkg::OP_LENGTH: begin
                  if (status.slot_ok) begin
                     state_in = ST_SCAN;
                  end
               end
               tld_pkg::OP_BCAST: begin
                  if (status.idx_ok) begin
                     state_in = ST_BCAST;
                  end
               end
               default: begin
               end
            endcase
         end
         ST_FILL: begin
            cmd.fill_wr = 1'b1;
            if (status.fill_last) begin
               state_in = ST_DONE;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_hit || status.scan_last) begin
               state_in = ST_DONE;
            end
         end
         ST_BCAST: begin
            cmd.bcast_step = 1'b1;
            if (status.bcast_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/tld_checker.sv
// port-level assertions for the task location directory and their bind
`default_nettype none

module tld_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [16:0] found_location,
   input logic [4:0]         known_length,
   input logic               index_error
);

   // clearing pass keeps requests out right after reset
   a_clear_after_reset: assert property (@(posedge clock) reset |=> !req_ready)
      else $error("request taken right after reset");

   // one request at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second request taken while busy");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(found_location) && $stable(known_length)
          && $stable(index_error)))
      else $error("stalled response changed");

   // a length result never comes with an error or a location
   a_length_alone: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (known_length != 5'd0)) |-> (!index_error && (found_location == 17'sd0)))
      else $error("length result mixed with other fields");

   // an index error carries no location other than zero or unknown
   a_error_location: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && index_error) |->
         ((found_location == 17'sd0) || (found_location == -17'sd1)))
      else $error("index error with a stored location");

endmodule

bind task_location_directory tld_checker u_tld_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_bus.valid),
   .req_ready      (req_bus.ready),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .found_location (rsp_bus.found_location),
   .known_length   (rsp_bus.known_length),
   .index_error    (rsp_bus.index_error)
);

`default_nettype wire

FILE: sim/task_location_directory_tb.sv
// self-checking testbench for the task location directory
`timescale 1ns / 100ps

module task_location_directory_tb;

   localparam int          CYCLE_LIMIT     = 400000;
   localparam int          RANDOM_ITEMS    = 1600;
   localparam int          SLOTS           = tld_pkg::LOCAL_SLOTS_DEF;
   localparam int          TASKS           = tld_pkg::TASKS_PER_APP_DEF;
   localparam logic [2:0]  OP_UNUSED_FIRST = tld_pkg::OP_BCAST + 3'd1;
   localparam logic [2:0]  OP_UNUSED_LAST  = 3'd7;

   typedef struct packed {
      logic signed [16:0] found;
      logic [4:0]         length;
      logic               index_error;
   } lookup_answer_type;

   typedef enum logic [1:0] {DRAIN_FREE, DRAIN_COIN, DRAIN_SLOW} drain_mode_type;

   logic clock = 1'b0;
   logic reset;

   tld_req_if req_bus ();
   tld_rsp_if rsp_bus ();

   task_location_directory dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always #10 clock = ~clock;

   // mirror of the directory contents
   logic signed [16:0] mirror_table [SLOTS][TASKS];
   logic [15:0]        mirror_owner [SLOTS];

   lookup_answer_type pending_answers [$];
   int                mismatches = 0;
   int                items_sent = 0;
   int                cycle_count = 0;
   int                burst_left = 0;
   bit                sender_quiet = 1'b0;
   int                drain_timer = 0;
   drain_mode_type    drain_mode = DRAIN_FREE;

   function automatic lookup_answer_type resolve_request(input logic [2:0] op,
                                                         input logic [1:0] slot,
                                                         input logic [15:0] tid,
                                                         input logic signed [16:0] loc);
      lookup_answer_type ans;
      int                idx;
      bit                idx_ok;
      ans = '0;
      idx = int'(tid & tld_pkg::INDEX_MASK);
      idx_ok = idx < TASKS;
      case (op)
         tld_pkg::OP_INIT: begin
            mirror_owner[slot] = tid;
            for (int i = 0; i < TASKS; i++) mirror_table[slot][i] = tld_pkg::LOC_UNKNOWN;
         end
         tld_pkg::OP_INSERT: begin
            if (idx_ok) mirror_table[slot][idx] = loc;
            else ans.index_error = 1'b1;
         end
         tld_pkg::OP_SEARCH: begin
            if (idx_ok) begin
               ans.found = mirror_table[slot][idx];
            end else begin
               ans.found = tld_pkg::LOC_UNKNOWN;
               ans.index_error = 1'b1;
            end
         end
         tld_pkg::OP_LENGTH: begin
            ans.length = 5'(TASKS);
            for (int i = TASKS - 1; i >= 0; i--)
               if (mirror_table[slot][i] == tld_pkg::LOC_UNKNOWN) ans.length = 5'(i);
         end
         tld_pkg::OP_BCAST: begin
            if (idx_ok) begin
               for (int s = 0; s < SLOTS; s++)
                  if ((mirror_owner[s] & tld_pkg::APP_MASK) == (tid & tld_pkg::APP_MASK))
                     mirror_table[s][idx] = loc;
            end else begin
               ans.index_error = 1'b1;
            end
         end
         default: ;
      endcase
      return ans;
   endfunction

   function automatic logic signed [16:0] random_location();
      logic [15:0] v;
      v = 16'($urandom_range(0, 65535));
      if ($urandom_range(0, 7) == 0) return tld_pkg::LOC_UNKNOWN;
      return {1'b0, v};
   endfunction

   function automatic logic [7:0] pick_app();
      case ($urandom_range(0, 5))
         0: return 8'h00;
         1: return 8'h01;
         2: return 8'h02;
         3: return 8'hFF;
         4: return 8'h5A;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [7:0] pick_index();
      if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
      return 8'($urandom_range(0, TASKS - 1));
   endfunction

   task automatic send_request(input logic [2:0] op, input logic [1:0] slot,
                               input logic [15:0] tid, input logic signed [16:0] loc);
      int gap;
      if (burst_left == 0) begin
         burst_left = int'($urandom_range(1, 16));
         gap = sender_quiet ? 0 : int'($urandom_range(0, 5));
         if (gap != 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_bus.valid    <= 1'b1;
      req_bus.req_type <= op;
      req_bus.slot     <= slot;
      req_bus.task_id  <= tid;
      req_bus.location <= loc;
      do @(posedge clock); while (!req_bus.ready);
      items_sent++;
   endtask

   task automatic test_fresh_directory();
      send_request(tld_pkg::OP_LENGTH, 2'd0, 16'h0000, '0);
      send_request(tld_pkg::OP_SEARCH, 2'd3, 16'h000F, '0);
      // unbound slots belong to application zero
      send_request(tld_pkg::OP_BCAST, 2'd1, 16'h000F, 17'sd0);
      send_request(tld_pkg::OP_SEARCH, 2'd2, 16'h000F, '0);
   endtask

   task automatic test_bind_and_lookup();
      send_request(tld_pkg::OP_INIT, 2'd0, 16'hFF00, tld_pkg::LOC_UNKNOWN);
      send_request(tld_pkg::OP_INIT, 2'd1, 16'hFFFF, 17'sd65535);
      send_request(tld_pkg::OP_INIT, 2'd2, 16'h1203, '0);
      send_request(tld_pkg::OP_INSERT, 2'd0, 16'hFF00, 17'sd65535);
      send_request(tld_pkg::OP_INSERT, 2'd0, 16'h000F, tld_pkg::LOC_UNKNOWN);
      send_request(tld_pkg::OP_SEARCH, 2'd0, 16'h0000, '0);
      send_request(tld_pkg::OP_LENGTH, 2'd0, 16'hFFFF, '0);
      send_request(tld_pkg::OP_SEARCH, 2'd3, 16'h000F, '0);
   endtask

   task automatic test_index_range();
      send_request(tld_pkg::OP_INSERT, 2'd0, 16'h00FF, 17'sd4660);
      send_request(tld_pkg::OP_INSERT, 2'd0, 16'h0010, 17'sd1);
      send_request(tld_pkg::OP_SEARCH, 2'd0, 16'hFFFF, '0);
      send_request(tld_pkg::OP_BCAST, 2'd0, 16'hFFFF, 17'sd5);
   endtask

   task automatic test_broadcast();
      send_request(tld_pkg::OP_BCAST, 2'd3, 16'hFF01, 17'sd0);
      send_request(tld_pkg::OP_LENGTH, 2'd0, 16'h0000, '0);
      send_request(tld_pkg::OP_SEARCH, 2'd1, 16'h0001, '0);
      send_request(tld_pkg::OP_SEARCH, 2'd2, 16'h0001, '0);
   endtask

   task automatic test_unknown_requests();
      for (int op = int'(OP_UNUSED_FIRST); op <= int'(OP_UNUSED_LAST); op++)
         send_request(3'(op), 2'd3, 16'hFFFF, tld_pkg::LOC_UNKNOWN);
   endtask

   task automatic test_random_sessions(input int target);
      int          first;
      int          fill;
      int          extra;
      logic [1:0]  s;
      logic [7:0]  app;
      logic [7:0]  idx;
      logic [7:0]  low;
      logic signed [16:0] loc;
      first = items_sent;
      while (items_sent - first < target) begin
         sender_quiet = ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 9) < 7) begin
            s = 2'($urandom_range(0, SLOTS - 1));
            app = pick_app();
            low = 8'($urandom_range(0, 255));
            send_request(tld_pkg::OP_INIT, s, {app, low}, random_location());
            fill = int'($urandom_range(0, TASKS));
            for (int k = 0; k < fill; k++) begin
               idx = 8'(k);
               loc = random_location();
               if (loc == tld_pkg::LOC_UNKNOWN && $urandom_range(0, 3) != 0) loc = 17'sd0;
               send_request(tld_pkg::OP_INSERT, s, {app, idx}, loc);
            end
            extra = int'($urandom_range(0, 8));
            repeat (extra) begin
               idx = pick_index();
               case ($urandom_range(0, 3))
                  0: send_request(tld_pkg::OP_SEARCH, s, {app, idx}, random_location());
                  1: send_request(tld_pkg::OP_BCAST, 2'($urandom_range(0, 3)),
                                  {($urandom_range(0, 3) == 0) ? pick_app() : app, idx},
                                  random_location());
                  2: send_request(tld_pkg::OP_INSERT, s, {app, idx}, random_location());
                  default: send_request(tld_pkg::OP_LENGTH, 2'($urandom_range(0, 3)),
                                        16'($urandom_range(0, 65535)), random_location());
               endcase
            end
            send_request(tld_pkg::OP_LENGTH, s, 16'($urandom_range(0, 65535)),
                         random_location());
         end else begin
            send_request(3'($urandom_range(int'(tld_pkg::OP_INIT), int'(OP_UNUSED_LAST))),
                         2'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)),
                         random_location());
         end
      end
   endtask

   // response drain pattern
   always @(posedge clock) begin
      if (drain_timer == 0) begin
         case ($urandom_range(0, 2))
            0: drain_mode = DRAIN_FREE;
            1: drain_mode = DRAIN_COIN;
            default: drain_mode = DRAIN_SLOW;
         endcase
         drain_timer = int'($urandom_range(50, 400));
      end else begin
         drain_timer--;
      end
      case (drain_mode)
         DRAIN_FREE: rsp_bus.ready <= 1'b1;
         DRAIN_COIN: rsp_bus.ready <= 1'($urandom_range(0, 1));
         default:    rsp_bus.ready <= ($urandom_range(0, 5) == 0);
      endcase
   end

   always @(posedge clock) begin : check_answers
      lookup_answer_type got;
      lookup_answer_type want;
      bit                bad;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready)
            pending_answers.push_back(resolve_request(req_bus.req_type, req_bus.slot,
                                                      req_bus.task_id, req_bus.location));
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = '{rsp_bus.found_location, rsp_bus.known_length, rsp_bus.index_error};
            if (pending_answers.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected response: found %0d length %0d error %0b",
                           got.found, got.length, got.index_error);
            end else begin
               want = pending_answers.pop_front();
               bad = 1'b0;
               if (got.found !== want.found) bad = 1'b1;
               if (got.length !== want.length) bad = 1'b1;
               if (got.index_error !== want.index_error) bad = 1'b1;
               if (bad) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch at %0t: found %0d/%0d length %0d/%0d error %0b/%0b",
                              $realtime, want.found, got.found, want.length, got.length,
                              want.index_error, got.index_error);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      reset            = 1'b1;
      req_bus.valid    = 1'b0;
      req_bus.req_type = tld_pkg::OP_INIT;
      req_bus.slot     = '0;
      req_bus.task_id  = '0;
      req_bus.location = '0;
      for (int s = 0; s < SLOTS; s++) begin
         mirror_owner[s] = '0;
         for (int i = 0; i < TASKS; i++) mirror_table[s][i] = tld_pkg::LOC_UNKNOWN;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_fresh_directory();
      test_bind_and_lookup();
      test_index_range();
      test_broadcast();
      test_unknown_requests();
      test_random_sessions(RANDOM_ITEMS);
      req_bus.valid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (TASKS + SLOTS + 8) @(posedge clock);
      if (mismatches == 0 && pending_answers.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
